/* design/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Types and constants shared by the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_SIZE_W = 7;

    typedef logic [WINDOW_SIZE_W-1:0] window_size_t;

    localparam window_size_t WINDOW_SIZE_RESET = window_size_t'(1);

endpackage

/* design/swm_deque_ram.sv */
// ----------------------------------------------------------------------------
// swm_deque_ram
// Deque entry store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module swm_deque_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WORD_W = 39
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read before write: a read of the entry being written returns the old word
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/swm_ctrl.sv */
// ----------------------------------------------------------------------------
// swm_ctrl
// Deque sequencer: expiry check, back-pop walk, append and result register.
// ----------------------------------------------------------------------------
module swm_ctrl #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_pkg::window_size_t          window_size,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           last_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] window_max,
    output logic                           sequence_end
);

    import swm_pkg::*;

    localparam int POS_MOD = 2 * MAX_WINDOW;
    localparam int HEAD_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int POS_W   = $clog2(POS_MOD);
    localparam int AGE_W   = POS_W + 1;
    localparam int SUM_W   = CNT_W + 1;
    localparam int CMP_W   = (WINDOW_SIZE_W > CNT_W) ? WINDOW_SIZE_W : CNT_W;
    localparam int WORD_W  = POS_W + SAMPLE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPIRE,
        S_POP,
        S_APPEND,
        S_RESULT
    } state_t;

    state_t                    state_reg, state_next;
    logic [HEAD_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      filled_reg, filled_next;
    logic                      fwd_reg, fwd_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg, sample_next;
    logic                      last_reg, last_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] max_reg, max_next;
    logic                      end_reg, end_next;

    logic                      ram_we;
    logic [HEAD_W-1:0]         ram_waddr;
    logic [WORD_W-1:0]         ram_wdata;
    logic                      ram_re;
    logic [HEAD_W-1:0]         ram_raddr;
    logic [WORD_W-1:0]         ram_rdata;

    logic signed [SAMPLE_WIDTH-1:0] rd_value;
    logic [POS_W-1:0]          rd_pos;
    logic [CNT_W-1:0]          win_k;
    logic [CMP_W-1:0]          ws_wide;
    logic [AGE_W-1:0]          age;
    logic                      expire;
    logic [HEAD_W-1:0]         head_e;
    logic [CNT_W-1:0]          count_e;
    logic                      pop;
    logic                      full;
    logic [HEAD_W-1:0]         head_a;
    logic [CNT_W-1:0]          count_a;
    logic                      res_go;
    logic signed [SAMPLE_WIDTH-1:0] front_value;

    function automatic logic [HEAD_W-1:0] slot(input logic [HEAD_W-1:0] base,
                                               input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(MAX_WINDOW))
        begin
            sum = sum - SUM_W'(MAX_WINDOW);
        end
        return sum[HEAD_W-1:0];
    endfunction

    swm_deque_ram #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (HEAD_W),
        .WORD_W (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_value = ram_rdata[SAMPLE_WIDTH-1:0];
    assign rd_pos   = ram_rdata[WORD_W-1:SAMPLE_WIDTH];

    // clamp the window to 1 .. MAX_WINDOW
    assign ws_wide = CMP_W'(window_size);
    always_comb
    begin
        if (window_size == '0)
        begin
            win_k = CNT_W'(1);
        end
        else if (ws_wide > CMP_W'(MAX_WINDOW))
        begin
            win_k = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_k = ws_wide[CNT_W-1:0];
        end
    end

    // age of the front entry, modulo the position count
    always_comb
    begin
        if (pos_reg >= rd_pos)
        begin
            age = AGE_W'(pos_reg) - AGE_W'(rd_pos);
        end
        else
        begin
            age = AGE_W'(pos_reg) + AGE_W'(POS_MOD) - AGE_W'(rd_pos);
        end
    end

    assign expire  = (count_reg != '0) && (age >= AGE_W'(win_k));
    assign head_e  = expire ? slot(head_reg, CNT_W'(1)) : head_reg;
    assign count_e = expire ? (count_reg - CNT_W'(1)) : count_reg;
    assign pop     = (rd_value <= sample_reg);
    assign full    = (count_reg >= CNT_W'(MAX_WINDOW));
    assign head_a  = full ? slot(head_reg, CNT_W'(1)) : head_reg;
    assign count_a = full ? CNT_W'(MAX_WINDOW - 1) : count_reg;
    assign res_go  = (state_reg == S_RESULT) && (!out_valid_reg || out_ready);
    assign front_value = fwd_reg ? sample_reg : rd_value;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        filled_next    = filled_reg;
        fwd_next       = fwd_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        max_next       = max_reg;
        end_next       = end_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot(head_a, count_a);
        ram_wdata      = {pos_reg, sample_reg};
        ram_re         = 1'b0;
        ram_raddr      = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample;
                    last_next   = last_sample;
                    ram_re      = 1'b1;
                    state_next  = S_EXPIRE;
                end
            end
            S_EXPIRE:
            begin
                head_next  = head_e;
                count_next = count_e;
                if (count_e != '0)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot(head_e, count_e - CNT_W'(1));
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_POP:
            begin
                // walk back while the tail is no larger than the new sample
                if (pop)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg > CNT_W'(1))
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = slot(head_reg, count_reg - CNT_W'(2));
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                ram_we     = 1'b1;
                head_next  = head_a;
                count_next = count_a + CNT_W'(1);
                ram_re     = 1'b1;
                ram_raddr  = head_a;
                // front is the entry being written when the deque was empty
                fwd_next   = (count_a == '0);
                if ((AGE_W'(pos_reg) + AGE_W'(1)) >= AGE_W'(win_k))
                begin
                    filled_next = 1'b1;
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_go)
                begin
                    if (filled_reg)
                    begin
                        out_valid_next = 1'b1;
                        max_next       = front_value;
                        end_next       = last_reg;
                    end
                    if (pos_reg == POS_W'(POS_MOD - 1))
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    if (last_reg)
                    begin
                        head_next   = '0;
                        count_next  = '0;
                        pos_next    = '0;
                        filled_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            filled_reg    <= 1'b0;
            fwd_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            end_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            filled_reg    <= filled_next;
            fwd_reg       <= fwd_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            end_reg       <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        max_reg    <= max_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign window_max   = max_reg;
    assign sequence_end = end_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_WINDOW))
        else $error("deque count above depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (HEAD_W+1)'(head_reg) < (HEAD_W+1)'(MAX_WINDOW))
        else $error("deque head out of range");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while one is in work");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result raised outside the result step");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_go && last_reg) |=> (count_reg == '0 && pos_reg == '0 && !filled_reg))
        else $error("sequence state not cleared after last sample");

endmodule

/* design/sliding_window_maximum.sv */
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Streaming maximum over a window of the most recent samples.
// ----------------------------------------------------------------------------
// Each sample goes through the expiry check, the back-pop walk, the append and
// the result step; a new request is taken only once the previous sample has
// left the result step. The back-pop walk reads the deque from the back
// through the single read port of the deque memory, one entry per cycle: the
// entries popped, plus one when a larger entry stays behind. A finished result
// waits in an output register, so the next request is taken while it is still
// pending. No result appears until window_size (clamped to 1 .. MAX_WINDOW)
// samples of a sequence have arrived; a request with last_sample set clears
// the sequence after its result. Deque memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           window_size_we,
    input  swm_pkg::window_size_t          window_size,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           last_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] window_max,
    output logic                           sequence_end
);

    import swm_pkg::*;

    window_size_t window_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else if (window_size_we)
        begin
            window_size_reg <= window_size;
        end
    end

    swm_ctrl #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_size  (window_size_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_max   (window_max),
        .sequence_end (sequence_end)
    );

endmodule
